FILE: rtl/hrp_pkg.sv
`default_nettype none

package hrp_pkg;

    localparam logic [1:0] PH_LINE  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;

    localparam logic [2:0] K_METHOD  = 3'd0;
    localparam logic [2:0] K_PATH    = 3'd1;
    localparam logic [2:0] K_QUERY   = 3'd2;
    localparam logic [2:0] K_VERSION = 3'd3;
    localparam logic [2:0] K_NAME    = 3'd4;
    localparam logic [2:0] K_VALUE   = 3'd5;
    localparam logic [2:0] K_BODY    = 3'd6;
    localparam logic [2:0] K_DELIM   = 3'd7;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_LINE    = 2'd1;
    localparam logic [1:0] E_COLON   = 2'd2;
    localparam logic [1:0] E_LEN_CHK = 2'd3;

    // request flag bits
    localparam int F_QUERY   = 0;
    localparam int F_CHUNKED = 1;
    localparam int F_CLOSE   = 2;
    localparam int F_LEN     = 3;
    localparam int F_SKIP    = 4;
    localparam int F_NEG     = 5;

    // header name candidates
    localparam logic [2:0] C_LEN  = 3'b001;
    localparam logic [2:0] C_TE   = 3'b010;
    localparam logic [2:0] C_CONN = 3'b100;

    // key words
    localparam logic [2:0] W_CLEN    = 3'd0;
    localparam logic [2:0] W_TENC    = 3'd1;
    localparam logic [2:0] W_CONN    = 3'd2;
    localparam logic [2:0] W_CHUNKED = 3'd3;
    localparam logic [2:0] W_CLOSE   = 3'd4;
    localparam logic [2:0] W_VER10   = 3'd5;

    localparam logic [8*14-1:0] S_CLEN    = "content-length";
    localparam logic [8*17-1:0] S_TENC    = "transfer-encoding";
    localparam logic [8*10-1:0] S_CONN    = "connection";
    localparam logic [8*7-1:0]  S_CHUNKED = "chunked";
    localparam logic [8*5-1:0]  S_CLOSE   = "close";
    localparam logic [8*8-1:0]  S_VER10   = "HTTP/1.0";

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    function automatic logic [4:0] key_len(input logic [2:0] k);
        logic [4:0] n;
        case (k)
            W_CLEN:    n = 5'd14;
            W_TENC:    n = 5'd17;
            W_CONN:    n = 5'd10;
            W_CHUNKED: n = 5'd7;
            W_CLOSE:   n = 5'd5;
            default:   n = 5'd8;
        endcase
        return n;
    endfunction

    // character at a position of a key word, zero past its end
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [6:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            W_CLEN:    if (pos < 7'd14) c = S_CLEN[8*(13 - pos) +: 8];
            W_TENC:    if (pos < 7'd17) c = S_TENC[8*(16 - pos) +: 8];
            W_CONN:    if (pos < 7'd10) c = S_CONN[8*(9 - pos) +: 8];
            W_CHUNKED: if (pos < 7'd7)  c = S_CHUNKED[8*(6 - pos) +: 8];
            W_CLOSE:   if (pos < 7'd5)  c = S_CLOSE[8*(4 - pos) +: 8];
            default:   if (pos < 7'd8)  c = S_VER10[8*(7 - pos) +: 8];
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  tail;
        logic [1:0]  word_index;
        logic [9:0]  word_length;
        logic [3:0]  version_match;
        logic [6:0]  name_position;
        logic [2:0]  name_candidates;
        logic [5:0]  value_length;
        logic [2:0]  word_matchers;
        logic [31:0] length_accum;
        logic [5:0]  flags;
        logic [1:0]  error_state;
        logic [5:0]  hdr_count;
        logic [31:0] body_remaining;
        logic [31:0] byte_total;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_LINE, tail: 8'h00, word_index: 2'd0, word_length: 10'd0,
        version_match: 4'd0, name_position: 7'd0, name_candidates: 3'b111,
        value_length: 6'd0, word_matchers: 3'd0, length_accum: 32'd0,
        flags: 6'd0, error_state: E_NONE, hdr_count: 6'd0,
        body_remaining: 32'd0, byte_total: 32'd0};

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  token_kind;
        logic [5:0]  header_slot;
        logic        headers_done;
        logic        request_done;
        logic        error_flag;
        logic [1:0]  error_code;
        logic [31:0] body_length;
        logic        chunked;
        logic        conn_persist;
        logic [31:0] consumed_bytes;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/hrp_step.sv
`default_nettype none

module hrp_step #(
    parameter int HDR_LIMIT   = 32,
    parameter int TARGET_MAX  = 1023,
    parameter int WORD_MAX    = 15,
    parameter int VALUE_SCAN  = 63,
    parameter int NAME_KEEP   = 127
) (
    input  wire hrp_pkg::state_t  cur,
    input  wire logic [7:0]       in_byte,
    output hrp_pkg::state_t       nxt,
    output hrp_pkg::result_t      res
);

    localparam logic [5:0] SLOT_NONE = 6'(HDR_LIMIT);

    function automatic hrp_pkg::state_t set_err(input hrp_pkg::state_t si,
                                                input logic [1:0] code);
        hrp_pkg::state_t s;
        s = si;
        if (s.error_state == hrp_pkg::E_NONE)
            s.error_state = code;
        return s;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == hrp_pkg::CH_SP) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic hrp_pkg::state_t scan_f(input hrp_pkg::state_t si,
                                               input logic [7:0] lb,
                                               input logic [2:0] w, input int flag);
        hrp_pkg::state_t s;
        logic [2:0] wlen;
        s = si;
        wlen = 3'(hrp_pkg::key_len(w));
        if (s.value_length < 6'(VALUE_SCAN)) begin
            s.value_length = s.value_length + 6'd1;
            if (s.word_matchers < wlen
                && lb == hrp_pkg::key_char(w, {4'd0, s.word_matchers}))
                s.word_matchers = s.word_matchers + 3'd1;
            else
                s.word_matchers = (lb == hrp_pkg::key_char(w, 7'd0)) ? 3'd1 : 3'd0;
            if (s.word_matchers >= wlen) begin
                s.flags[flag] = 1'b1;
                s.word_matchers = 3'd0;
            end
        end
        return s;
    endfunction

    function automatic hrp_pkg::state_t length_f(input hrp_pkg::state_t si,
                                                 input logic [7:0] b);
        hrp_pkg::state_t s;
        logic dig;
        logic take;
        logic [35:0] v;
        s = si;
        dig = (b >= 8'h30 && b <= 8'h39);
        take = 1'b0;
        v = '0;
        if (s.word_matchers == 3'd0) begin
            if (is_ws(b)) begin
                take = 1'b0;
            end
            else if (b == hrp_pkg::CH_PLUS || b == hrp_pkg::CH_MINUS) begin
                if (b == hrp_pkg::CH_MINUS)
                    s.flags[hrp_pkg::F_NEG] = 1'b1;
                s.word_matchers = 3'd1;
            end
            else if (!dig) begin
                s.word_matchers = 3'd2;
            end
            else begin
                s.word_matchers = 3'd1;
                take = 1'b1;
            end
        end
        else if (s.word_matchers != 3'd1 || !dig) begin
            s.word_matchers = 3'd2;
        end
        else begin
            take = 1'b1;
        end
        if (take) begin
            v = ({4'd0, s.length_accum} << 3) + ({4'd0, s.length_accum} << 1)
                + {32'd0, b[3:0]};
            s.length_accum = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
        end
        return s;
    endfunction

    function automatic hrp_pkg::state_t content_f(input hrp_pkg::state_t si,
                                                  input logic [7:0] b,
                                                  output logic [2:0] kind);
        hrp_pkg::state_t s;
        logic [7:0] lb;
        logic [2:0] hit;
        logic [9:0] limit;
        s = si;
        kind = hrp_pkg::K_DELIM;
        lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        hit = '0;
        limit = '0;
        case (s.phase)
            hrp_pkg::PH_LINE: begin
                if (is_ws(b)) begin
                    if (s.word_length != 10'd0) begin
                        if (s.word_index < 2'd3)
                            s.word_index = s.word_index + 2'd1;
                        s.word_length = 10'd0;
                    end
                end
                else if (s.word_index != 2'd3) begin
                    limit = (s.word_index == 2'd1) ? 10'(TARGET_MAX) : 10'(WORD_MAX);
                    if (s.word_length >= limit)
                        s = set_err(s, hrp_pkg::E_LINE);
                    else
                        s.word_length = s.word_length + 10'd1;
                    if (s.word_index == 2'd0) begin
                        kind = hrp_pkg::K_METHOD;
                    end
                    else if (s.word_index == 2'd1) begin
                        if (!s.flags[hrp_pkg::F_QUERY] && b == hrp_pkg::CH_QMARK)
                            s.flags[hrp_pkg::F_QUERY] = 1'b1;
                        else
                            kind = s.flags[hrp_pkg::F_QUERY] ? hrp_pkg::K_QUERY
                                                             : hrp_pkg::K_PATH;
                    end
                    else begin
                        if (s.version_match < 4'd8 && b == hrp_pkg::key_char(
                                hrp_pkg::W_VER10, {3'd0, s.version_match}))
                            s.version_match = s.version_match + 4'd1;
                        else
                            s.version_match = 4'd15;
                        kind = hrp_pkg::K_VERSION;
                    end
                end
            end
            hrp_pkg::PH_NAME: begin
                if (b == hrp_pkg::CH_COLON) begin
                    for (int i = 0; i < 3; i++)
                        if (s.name_candidates[i]
                            && s.name_position == 7'(hrp_pkg::key_len(3'(i))))
                            hit = 3'b001 << i;
                    s.name_candidates = hit;
                    s.phase = hrp_pkg::PH_VALUE;
                    s.value_length = 6'd0;
                    s.word_matchers = 3'd0;
                    s.flags[hrp_pkg::F_SKIP] = 1'b1;
                    if (hit == hrp_pkg::C_LEN && s.error_state == hrp_pkg::E_NONE) begin
                        s.length_accum = 32'd0;
                        s.flags[hrp_pkg::F_NEG] = 1'b0;
                    end
                end
                else begin
                    for (int i = 0; i < 3; i++)
                        if (s.name_candidates[i] && (s.name_position
                                >= 7'(hrp_pkg::key_len(3'(i)))
                                || lb != hrp_pkg::key_char(3'(i), s.name_position)))
                            s.name_candidates[i] = 1'b0;
                    if (s.name_position < 7'(NAME_KEEP))
                        s.name_position = s.name_position + 7'd1;
                    kind = hrp_pkg::K_NAME;
                end
            end
            default: begin
                if (!(s.flags[hrp_pkg::F_SKIP] && b == hrp_pkg::CH_SP)) begin
                    s.flags[hrp_pkg::F_SKIP] = 1'b0;
                    kind = hrp_pkg::K_VALUE;
                    if (s.error_state == hrp_pkg::E_NONE) begin
                        if (s.name_candidates == hrp_pkg::C_LEN)
                            s = length_f(s, b);
                        else if (s.name_candidates == hrp_pkg::C_TE)
                            s = scan_f(s, lb, hrp_pkg::W_CHUNKED, hrp_pkg::F_CHUNKED);
                        else if (s.name_candidates == hrp_pkg::C_CONN)
                            s = scan_f(s, lb, hrp_pkg::W_CLOSE, hrp_pkg::F_CLOSE);
                    end
                end
            end
        endcase
        return s;
    endfunction

    function automatic hrp_pkg::state_t end_line_f(input hrp_pkg::state_t si,
                                                   output logic blank);
        hrp_pkg::state_t s;
        s = si;
        blank = 1'b0;
        if (s.phase == hrp_pkg::PH_LINE) begin
            if (s.word_length != 10'd0 && s.word_index < 2'd3)
                s.word_index = s.word_index + 2'd1;
            if (s.word_index < 2'd3)
                s = set_err(s, hrp_pkg::E_LINE);
        end
        else if (s.phase == hrp_pkg::PH_NAME) begin
            if (s.name_position == 7'd0) begin
                blank = 1'b1;
            end
            else begin
                s = set_err(s, hrp_pkg::E_COLON);
                if (s.hdr_count < 6'(HDR_LIMIT))
                    s.hdr_count = s.hdr_count + 6'd1;
            end
        end
        else begin
            if (s.name_candidates == hrp_pkg::C_LEN && s.error_state == hrp_pkg::E_NONE) begin
                if (s.flags[hrp_pkg::F_NEG] && s.length_accum != 32'd0) begin
                    s.flags[hrp_pkg::F_LEN] = 1'b0;
                    s.length_accum = 32'd0;
                end
                else begin
                    s.flags[hrp_pkg::F_LEN] = 1'b1;
                end
            end
            if (s.hdr_count < 6'(HDR_LIMIT))
                s.hdr_count = s.hdr_count + 6'd1;
        end
        if (!blank) begin
            s.phase = hrp_pkg::PH_NAME;
            s.name_position = 7'd0;
            s.name_candidates = 3'b111;
        end
        return s;
    endfunction

    always_comb begin
        hrp_pkg::state_t s;
        logic [2:0]  kind;
        logic [2:0]  unused_kind;
        logic [5:0]  slot;
        logic        hd;
        logic        rd;
        logic        pend;
        logic        summ;
        logic [31:0] len;

        s = cur;
        kind = hrp_pkg::K_DELIM;
        unused_kind = hrp_pkg::K_DELIM;
        slot = SLOT_NONE;
        hd = 1'b0;
        rd = 1'b0;
        pend = 1'b0;
        len = 32'd0;

        if (s.byte_total != 32'hFFFF_FFFF)
            s.byte_total = s.byte_total + 32'd1;
        if (s.phase == hrp_pkg::PH_BODY) begin
            kind = hrp_pkg::K_BODY;
            if (s.body_remaining != 32'd0)
                s.body_remaining = s.body_remaining - 32'd1;
            if (s.body_remaining == 32'd0)
                rd = 1'b1;
        end
        else begin
            if (s.phase != hrp_pkg::PH_LINE)
                slot = s.hdr_count;
            pend = (s.tail == hrp_pkg::CH_CR);
            s.tail = in_byte;
            if (pend && in_byte == hrp_pkg::CH_LF) begin
                s = end_line_f(s, hd);
            end
            else begin
                // lone cr turns out to be a content byte of its line
                if (pend)
                    s = content_f(s, hrp_pkg::CH_CR, unused_kind);
                if (in_byte != hrp_pkg::CH_CR)
                    s = content_f(s, in_byte, kind);
            end
        end

        if (hd) begin
            if (s.flags[hrp_pkg::F_LEN] && s.flags[hrp_pkg::F_CHUNKED])
                s = set_err(s, hrp_pkg::E_LEN_CHK);
            len = s.flags[hrp_pkg::F_LEN] ? s.length_accum : 32'd0;
            if (s.error_state != hrp_pkg::E_NONE || len == 32'd0) begin
                rd = 1'b1;
            end
            else begin
                s.phase = hrp_pkg::PH_BODY;
                s.body_remaining = len;
            end
        end

        summ = hd || rd;
        res.data_byte      = in_byte;
        res.token_kind     = kind;
        res.header_slot    = slot;
        res.headers_done   = hd;
        res.request_done   = rd;
        res.error_flag     = summ && (s.error_state != hrp_pkg::E_NONE);
        res.error_code     = summ ? s.error_state : hrp_pkg::E_NONE;
        res.body_length    = (summ && s.flags[hrp_pkg::F_LEN]) ? s.length_accum : 32'd0;
        res.chunked        = summ && s.flags[hrp_pkg::F_CHUNKED];
        res.conn_persist   = summ && (s.version_match != 4'd8)
                             && !s.flags[hrp_pkg::F_CLOSE];
        res.consumed_bytes = rd ? s.byte_total : 32'd0;

        nxt = rd ? hrp_pkg::STATE_RESET : s;
    end

endmodule

`default_nettype wire

FILE: rtl/http_request_header_parser_top.sv
// http request header parser
// input channel: in_valid / in_ready with in_byte, one byte of the request
// stream per request. output channel: out_valid / out_ready with one tagged
// result per input byte (token kind, header slot, and the summary fields on
// headers_done / request_done bytes).
// a result is registered and appears in the cycle after its byte is accepted.
// throughput: one byte per cycle while out_ready is high; the parser state
// is updated in the same cycle the byte is taken, so bytes follow back to
// back with no bubbles.
// the output register holds a result until it is taken; while it is full
// and out_ready is low, in_ready drops and the parser state holds.
// reset: parser returns to the start of a request line, output is empty.
// after a request_done result the parser starts a fresh request with the
// next byte.
`default_nettype none

module http_request_header_parser_top #(
    parameter int HDR_LIMIT   = 32,
    parameter int TARGET_MAX  = 1023,
    parameter int WORD_MAX    = 15,
    parameter int VALUE_SCAN  = 63,
    parameter int NAME_KEEP   = 127
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic [2:0]       token_kind,
    output logic [5:0]       header_slot,
    output logic             headers_done,
    output logic             request_done,
    output logic             error_flag,
    output logic [1:0]       error_code,
    output logic [31:0]      body_length,
    output logic             chunked,
    output logic             conn_persist,
    output logic [31:0]      consumed_bytes
);

    hrp_pkg::state_t  st_reg;
    hrp_pkg::state_t  st_next;
    hrp_pkg::result_t res_reg;
    hrp_pkg::result_t res_next;
    logic             out_valid_reg;
    logic             take;

    hrp_step #(
        .HDR_LIMIT   (HDR_LIMIT),
        .TARGET_MAX  (TARGET_MAX),
        .WORD_MAX    (WORD_MAX),
        .VALUE_SCAN  (VALUE_SCAN),
        .NAME_KEEP   (NAME_KEEP)
    ) u_step (
        .cur     (st_reg),
        .in_byte (in_byte),
        .nxt     (st_next),
        .res     (res_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= hrp_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                st_reg <= st_next;
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = res_reg.data_byte;
    assign token_kind     = res_reg.token_kind;
    assign header_slot    = res_reg.header_slot;
    assign headers_done   = res_reg.headers_done;
    assign request_done   = res_reg.request_done;
    assign error_flag     = res_reg.error_flag;
    assign error_code     = res_reg.error_code;
    assign body_length    = res_reg.body_length;
    assign chunked        = res_reg.chunked;
    assign conn_persist   = res_reg.conn_persist;
    assign consumed_bytes = res_reg.consumed_bytes;

endmodule

`default_nettype wire

FILE: rtl/hrp_checker.sv
`default_nettype none

module hrp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  data_byte,
    input wire logic [2:0]  token_kind,
    input wire logic        headers_done,
    input wire logic        request_done,
    input wire logic        error_flag,
    input wire logic [1:0]  error_code,
    input wire logic [31:0] body_length,
    input wire logic [31:0] consumed_bytes
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte))
        else $error("stalled result changed");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> error_code != hrp_pkg::E_NONE)
        else $error("error flag without code");

    a_summary_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !headers_done && !request_done |->
            !error_flag && body_length == 32'd0 && consumed_bytes == 32'd0)
        else $error("summary fields outside header end");

    a_body_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == hrp_pkg::K_BODY |-> !headers_done)
        else $error("body byte flagged as header end");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && headers_done && error_flag |-> request_done)
        else $error("rejected request not closed");

endmodule

bind http_request_header_parser_top hrp_checker u_hrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .token_kind     (token_kind),
    .headers_done   (headers_done),
    .request_done   (request_done),
    .error_flag     (error_flag),
    .error_code     (error_code),
    .body_length    (body_length),
    .consumed_bytes (consumed_bytes)
);

`default_nettype wire

FILE: tb/http_request_header_parser_top_test.sv
`default_nettype none

module http_request_header_parser_top_test;

    localparam int MAX_HDR = 32;
    localparam int TGT_MAX = 1023;
    localparam int WRD_MAX = 15;
    localparam int SCAN_MAX = 63;
    localparam int KEEP_MAX = 127;
    localparam int RANDOM_BYTES = 1900;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic [2:0]  token_kind;
    logic [5:0]  header_slot;
    logic        headers_done;
    logic        request_done;
    logic        error_flag;
    logic [1:0]  error_code;
    logic [31:0] body_length;
    logic        chunked;
    logic        conn_persist;
    logic [31:0] consumed_bytes;

    http_request_header_parser_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .data_byte(data_byte), .token_kind(token_kind), .header_slot(header_slot),
        .headers_done(headers_done), .request_done(request_done),
        .error_flag(error_flag), .error_code(error_code),
        .body_length(body_length), .chunked(chunked), .conn_persist(conn_persist),
        .consumed_bytes(consumed_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // parser model state
    logic [1:0]  p_phase;
    logic [7:0]  p_last;
    int          p_widx, p_wlen, p_ver, p_npos, p_vlen, p_match, p_hcnt;
    logic [2:0]  p_cand;
    logic [31:0] p_accum;
    logic [5:0]  p_flags;
    logic [1:0]  p_err;
    logic [31:0] p_body_left;
    logic [31:0] p_total;

    string hdr_names[3] = '{"content-length", "transfer-encoding", "connection"};
    string ver_10 = "HTTP/1.0";

    hrp_pkg::result_t parsed_q[$];
    logic [7:0] stream_q[$];
    int errors_seen, bytes_sent, requests_done, rejected_seen, bodies_seen;

    function automatic void parser_clear();
        p_phase = hrp_pkg::PH_LINE; p_last = 8'h00; p_widx = 0; p_wlen = 0; p_ver = 0;
        p_npos = 0; p_cand = 3'b111; p_vlen = 0; p_match = 0; p_accum = 0;
        p_flags = 0; p_err = hrp_pkg::E_NONE; p_hcnt = 0; p_body_left = 0; p_total = 0;
    endfunction

    function automatic bit is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic void raise(logic [1:0] code);
        if (p_err == hrp_pkg::E_NONE)
            p_err = code;
    endfunction

    function automatic logic [2:0] line_char(logic [7:0] b);
        int lim;
        if (is_space(b))
        begin
            if (p_wlen > 0)
            begin
                if (p_widx < 3)
                    p_widx++;
                p_wlen = 0;
            end
            return hrp_pkg::K_DELIM;
        end
        if (p_widx >= 3)
            return hrp_pkg::K_DELIM;
        lim = (p_widx == 1) ? TGT_MAX : WRD_MAX;
        if (p_wlen >= lim)
            raise(hrp_pkg::E_LINE);
        else
            p_wlen++;
        if (p_widx == 0)
            return hrp_pkg::K_METHOD;
        if (p_widx == 1)
        begin
            if (!p_flags[hrp_pkg::F_QUERY] && b == hrp_pkg::CH_QMARK)
            begin
                p_flags[hrp_pkg::F_QUERY] = 1'b1;
                return hrp_pkg::K_DELIM;
            end
            return p_flags[hrp_pkg::F_QUERY] ? hrp_pkg::K_QUERY : hrp_pkg::K_PATH;
        end
        if (p_ver < 8 && b == ver_10[p_ver])
            p_ver++;
        else
            p_ver = 15;
        return hrp_pkg::K_VERSION;
    endfunction

    function automatic logic [2:0] name_char(logic [7:0] b);
        logic [2:0] hit;
        logic [7:0] lb;
        lb = fold_case(b);
        hit = 3'b000;
        if (b == hrp_pkg::CH_COLON)
        begin
            for (int i = 0; i < 3; i++)
                if (p_cand[i] && p_npos == hdr_names[i].len())
                    hit = 3'b001 << i;
            p_cand = hit;
            p_phase = hrp_pkg::PH_VALUE;
            p_vlen = 0;
            p_match = 0;
            p_flags[hrp_pkg::F_SKIP] = 1'b1;
            if (hit == hrp_pkg::C_LEN && p_err == hrp_pkg::E_NONE)
            begin
                p_accum = 0;
                p_flags[hrp_pkg::F_NEG] = 1'b0;
            end
            return hrp_pkg::K_DELIM;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (p_cand[i])
            begin
                if (p_npos >= hdr_names[i].len())
                    p_cand[i] = 1'b0;
                else if (lb != hdr_names[i][p_npos])
                    p_cand[i] = 1'b0;
            end
        end
        if (p_npos < KEEP_MAX)
            p_npos++;
        return hrp_pkg::K_NAME;
    endfunction

    function automatic void length_char(logic [7:0] b);
        logic [63:0] v;
        bit dig;
        dig = (b >= 8'h30 && b <= 8'h39);
        if (p_match == 0)
        begin
            if (is_space(b))
                return;
            if (b == hrp_pkg::CH_PLUS || b == hrp_pkg::CH_MINUS)
            begin
                if (b == hrp_pkg::CH_MINUS)
                    p_flags[hrp_pkg::F_NEG] = 1'b1;
                p_match = 1;
                return;
            end
            if (!dig)
            begin
                p_match = 2;
                return;
            end
            p_match = 1;
        end
        else if (p_match != 1 || !dig)
        begin
            p_match = 2;
            return;
        end
        v = 64'(p_accum) * 10 + 64'(b - 8'h30);
        p_accum = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void word_scan(logic [7:0] b, string w, int flag);
        logic [7:0] lb;
        lb = fold_case(b);
        if (p_vlen >= SCAN_MAX)
            return;
        p_vlen++;
        if (p_match < w.len() && lb == w[p_match])
            p_match++;
        else
            p_match = (lb == w[0]) ? 1 : 0;
        if (p_match >= w.len())
        begin
            p_flags[flag] = 1'b1;
            p_match = 0;
        end
    endfunction

    function automatic logic [2:0] value_char(logic [7:0] b);
        if (p_flags[hrp_pkg::F_SKIP] && b == hrp_pkg::CH_SP)
            return hrp_pkg::K_DELIM;
        p_flags[hrp_pkg::F_SKIP] = 1'b0;
        if (p_err != hrp_pkg::E_NONE)
            return hrp_pkg::K_VALUE;
        if (p_cand == hrp_pkg::C_LEN)
            length_char(b);
        else if (p_cand == hrp_pkg::C_TE)
            word_scan(b, "chunked", hrp_pkg::F_CHUNKED);
        else if (p_cand == hrp_pkg::C_CONN)
            word_scan(b, "close", hrp_pkg::F_CLOSE);
        return hrp_pkg::K_VALUE;
    endfunction

    function automatic logic [2:0] content_char(logic [7:0] b);
        if (p_phase == hrp_pkg::PH_LINE)
            return line_char(b);
        if (p_phase == hrp_pkg::PH_NAME)
            return name_char(b);
        return value_char(b);
    endfunction

    function automatic bit close_line();
        if (p_phase == hrp_pkg::PH_LINE)
        begin
            if (p_wlen > 0 && p_widx < 3)
                p_widx++;
            if (p_widx < 3)
                raise(hrp_pkg::E_LINE);
        end
        else if (p_phase == hrp_pkg::PH_NAME)
        begin
            if (p_npos == 0)
                return 1'b1;
            raise(hrp_pkg::E_COLON);
            if (p_hcnt < MAX_HDR)
                p_hcnt++;
        end
        else
        begin
            if (p_cand == hrp_pkg::C_LEN && p_err == hrp_pkg::E_NONE)
            begin
                if (p_flags[hrp_pkg::F_NEG] && p_accum != 0)
                begin
                    p_flags[hrp_pkg::F_LEN] = 1'b0;
                    p_accum = 0;
                end
                else
                    p_flags[hrp_pkg::F_LEN] = 1'b1;
            end
            if (p_hcnt < MAX_HDR)
                p_hcnt++;
        end
        p_phase = hrp_pkg::PH_NAME;
        p_npos = 0;
        p_cand = 3'b111;
        return 1'b0;
    endfunction

    function automatic hrp_pkg::result_t parse_byte(logic [7:0] b);
        hrp_pkg::result_t r;
        logic [31:0] blen;
        bit pend, hd, rd, summ;
        r = '0;
        hd = 0;
        rd = 0;
        r.header_slot = 6'(MAX_HDR);
        if (p_total != 32'hFFFF_FFFF)
            p_total++;
        if (p_phase == hrp_pkg::PH_BODY)
        begin
            r.token_kind = hrp_pkg::K_BODY;
            if (p_body_left > 0)
                p_body_left--;
            if (p_body_left == 0)
                rd = 1;
        end
        else
        begin
            if (p_phase != hrp_pkg::PH_LINE)
                r.header_slot = 6'(p_hcnt);
            pend = (p_last == hrp_pkg::CH_CR);
            p_last = b;
            if (pend && b == hrp_pkg::CH_LF)
            begin
                r.token_kind = hrp_pkg::K_DELIM;
                hd = close_line();
            end
            else
            begin
                if (pend)
                    void'(content_char(hrp_pkg::CH_CR));
                r.token_kind = (b == hrp_pkg::CH_CR) ? hrp_pkg::K_DELIM : content_char(b);
            end
        end
        if (hd)
        begin
            if (p_flags[hrp_pkg::F_LEN] && p_flags[hrp_pkg::F_CHUNKED])
                raise(hrp_pkg::E_LEN_CHK);
            blen = p_flags[hrp_pkg::F_LEN] ? p_accum : 32'd0;
            if (p_err != hrp_pkg::E_NONE || blen == 0)
                rd = 1;
            else
            begin
                p_phase = hrp_pkg::PH_BODY;
                p_body_left = blen;
            end
        end
        summ = hd || rd;
        r.data_byte = b;
        r.headers_done = hd;
        r.request_done = rd;
        r.error_flag = summ && p_err != hrp_pkg::E_NONE;
        r.error_code = summ ? p_err : hrp_pkg::E_NONE;
        r.body_length = (summ && p_flags[hrp_pkg::F_LEN]) ? p_accum : 32'd0;
        r.chunked = summ && p_flags[hrp_pkg::F_CHUNKED];
        r.conn_persist = summ && p_ver != 8 && !p_flags[hrp_pkg::F_CLOSE];
        r.consumed_bytes = rd ? p_total : 32'd0;
        if (rd)
            parser_clear();
        return r;
    endfunction

    // request stream construction
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endfunction

    function automatic string mixed_case(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1))
                t[i] = t[i] - 8'd32;
        return t;
    endfunction

    function automatic string rand_word(int n);
        string t;
        t = "";
        for (int i = 0; i < n; i++)
            t = {t, string'(8'($urandom_range(8'h21, 8'h7E)))};
        return t;
    endfunction

    function automatic void build_request();
        int sel, nh, body_bytes;
        bit has_te;
        string m;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            repeat ($urandom_range(1, 30))
                stream_q.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(0, 4))
            0: m = "GET";
            1: m = "POST";
            2: m = "DELETE";
            default: m = rand_word((sel == 1) ? $urandom_range(14, 18) : $urandom_range(1, 6));
        endcase
        put_text({m, " /", rand_word($urandom_range(0, 10))});
        if ($urandom_range(0, 2) == 0)
            put_text({"?", rand_word($urandom_range(0, 6))});
        if (sel != 2)
        begin
            case ($urandom_range(0, 3))
                0: put_text(" HTTP/1.0");
                1: put_text(" HTTP/1.0x");
                default: put_text(" HTTP/1.1");
            endcase
        end
        if (sel == 3)
            put_text(" extra");
        put_text("\r\n");
        body_bytes = 0;
        has_te = 0;
        nh = $urandom_range(0, 5);
        for (int h = 0; h < nh; h++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    body_bytes = $urandom_range(0, 20);
                    case ($urandom_range(0, 5))
                        0: put_text({mixed_case("content-length"), ": +",
                                     $sformatf("%0d", body_bytes)});
                        1: begin put_text("Content-Length: -0"); body_bytes = 0; end
                        2: begin put_text("content-length:  -7"); body_bytes = 0; end
                        3: put_text({"Content-Length: 00", $sformatf("%0d", body_bytes), "x"});
                        default: put_text({"Content-Length: ", $sformatf("%0d", body_bytes)});
                    endcase
                end
                2:
                begin
                    has_te = 1;
                    put_text({mixed_case("transfer-encoding"), ": gzip, ",
                              mixed_case("chunked")});
                    if ($urandom_range(0, 1))
                    begin
                        put_text("\r\nContent-Length: 99999999999");
                        body_bytes = 0;
                    end
                end
                3: put_text({"Connection: ", ($urandom_range(0, 1) ? mixed_case("close")
                                                                    : "keep-alive")});
                4: put_text({rand_word($urandom_range(1, 8)), " no colon"});
                5: put_text({"X-", rand_word(3), ": a\rb\r", rand_word(4)});
                default: put_text({rand_word($urandom_range(1, 12)), ": ",
                                   rand_word($urandom_range(0, 20))});
            endcase
            put_text("\r\n");
        end
        put_text("\r\n");
        if (has_te)
            body_bytes = 0;
        repeat (body_bytes)
            stream_q.push_back(8'($urandom));
    endfunction

    // directed rows: byte and, where obvious, the expected tag and summary
    typedef struct {
        logic [7:0]  b;
        bit          typed;
        logic [2:0]  kind;
        bit          hd;
        bit          rd;
        bit          ka;
        logic [31:0] total;
    } row_t;

    row_t directed[22] = '{
        '{"G",   1, hrp_pkg::K_METHOD,  0, 0, 0, 0},
        '{"E",   0, hrp_pkg::K_METHOD,  0, 0, 0, 0},
        '{"T",   0, hrp_pkg::K_METHOD,  0, 0, 0, 0},
        '{" ",   1, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{"/",   1, hrp_pkg::K_PATH,    0, 0, 0, 0},
        '{8'hFF, 1, hrp_pkg::K_PATH,    0, 0, 0, 0},
        '{8'h00, 1, hrp_pkg::K_PATH,    0, 0, 0, 0},
        '{"?",   1, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{"q",   1, hrp_pkg::K_QUERY,   0, 0, 0, 0},
        '{" ",   0, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{"H",   1, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"T",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"T",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"P",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"/",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"1",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{".",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{"0",   0, hrp_pkg::K_VERSION, 0, 0, 0, 0},
        '{8'h0D, 1, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{8'h0A, 1, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{8'h0D, 1, hrp_pkg::K_DELIM,   0, 0, 0, 0},
        '{8'h0A, 1, hrp_pkg::K_DELIM,   1, 1, 0, 22}
    };

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(logic [7:0] b, output hrp_pkg::result_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        r = parse_byte(b);
        bytes_sent++;
    endtask

    // out_ready: bursts of random stalls alternating with stretches of none
    int stall_left = 0;
    int calm_left = 0;
    always @(posedge clk)
    begin
        if (calm_left > 0)
        begin
            calm_left <= calm_left - 1;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0: calm_left <= $urandom_range(50, 300);
                1: stall_left <= $urandom_range(10, 40);
                2, 3, 4: stall_left <= $urandom_range(0, 2);
                default: ;
            endcase
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        hrp_pkg::result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (parsed_q.size() == 0)
            begin
                $error("result with no request pending: data_byte %0h", data_byte);
                errors_seen++;
            end
            else
            begin
                e = parsed_q.pop_front();
                compare("data_byte", 32'(e.data_byte), 32'(data_byte));
                compare("token_kind", 32'(e.token_kind), 32'(token_kind));
                compare("header_slot", 32'(e.header_slot), 32'(header_slot));
                compare("headers_done", 32'(e.headers_done), 32'(headers_done));
                compare("request_done", 32'(e.request_done), 32'(request_done));
                compare("error_flag", 32'(e.error_flag), 32'(error_flag));
                compare("error_code", 32'(e.error_code), 32'(error_code));
                compare("body_length", e.body_length, body_length);
                compare("chunked", 32'(e.chunked), 32'(chunked));
                compare("conn_persist", 32'(e.conn_persist), 32'(conn_persist));
                compare("consumed_bytes", e.consumed_bytes, consumed_bytes);
                if (request_done)
                    requests_done++;
                if (request_done && error_flag)
                    rejected_seen++;
                if (token_kind == hrp_pkg::K_BODY)
                    bodies_seen++;
            end
        end
    end

    initial
    begin
        #4000000;
        $display("timed out with %0d results outstanding", parsed_q.size());
        $display("http_request_header_parser_top_test: errors");
        $finish;
    end

    initial
    begin
        hrp_pkg::result_t r;
        int waited;
        errors_seen = 0;
        bytes_sent = 0;
        requests_done = 0;
        rejected_seen = 0;
        bodies_seen = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        parser_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_byte(directed[i].b, r);
            if (directed[i].typed)
            begin
                r.token_kind = directed[i].kind;
                r.headers_done = directed[i].hd;
                r.request_done = directed[i].rd;
                r.conn_persist = directed[i].ka;
                r.consumed_bytes = directed[i].total;
            end
            parsed_q.push_back(r);
        end

        while (stream_q.size() < RANDOM_BYTES)
            build_request();
        while (stream_q.size() > 0)
        begin
            send_byte(stream_q.pop_front(), r);
            parsed_q.push_back(r);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (parsed_q.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (parsed_q.size() > 0)
        begin
            $error("%0d results never arrived", parsed_q.size());
            errors_seen++;
        end
        $display("sent %0d bytes; %0d requests completed, %0d rejected, %0d body bytes",
                 bytes_sent, requests_done, rejected_seen, bodies_seen);
        if (errors_seen == 0)
            $display("http_request_header_parser_top_test: clean");
        else
            $display("http_request_header_parser_top_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
